[rtl/integer_radix_converter_top_macros.svh]
// ----------------------------------------------------------------------------
// integer radix converter assertion macros
// shared property forms for the converter checks
// ----------------------------------------------------------------------------
`ifndef INTEGER_RADIX_CONVERTER_TOP_MACROS_SVH
`define INTEGER_RADIX_CONVERTER_TOP_MACROS_SVH

// same-cycle implication
`define IRC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/irc_pkg.sv]
// ----------------------------------------------------------------------------
// irc_pkg
// widths, constants and shared types of the integer radix converter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package irc_pkg;

    localparam int VALUE_W     = 31;
    localparam int RADIX_W     = 5;
    localparam int CHAR_W      = 7;
    localparam int DIGIT_W     = 4;
    localparam int REM_W       = DIGIT_W + 1;
    localparam int DIGIT_SLOTS = 32;
    localparam int SLOT_IDX_W  = $clog2(DIGIT_SLOTS);
    localparam int COUNT_W     = $clog2(DIGIT_SLOTS + 1);

    // divider: quotient bits resolved per cycle
    localparam int DIV_W      = 32;
    localparam int DIV_BITS   = 8;
    localparam int DIV_CYCLES = DIV_W / DIV_BITS;
    localparam int STEP_W     = $clog2(DIV_CYCLES);

    localparam int FIFO_DEPTH   = 2;
    localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
    localparam int FIFO_COUNT_W = $clog2(FIFO_DEPTH + 1);

    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = PADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_RADIX   = REG_IDX_W'(0);
    localparam logic [RADIX_W-1:0]   RADIX_RESET = RADIX_W'(10);
    localparam logic [RADIX_W-1:0]   BASE_MIN    = RADIX_W'(2);
    localparam logic [RADIX_W-1:0]   BASE_MAX    = RADIX_W'(16);

    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = CHAR_W'(48);
    localparam logic [CHAR_W-1:0]  CHAR_A     = CHAR_W'(65);
    localparam logic [DIGIT_W-1:0] DIGIT_TEN  = DIGIT_W'(10);

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [RADIX_W-1:0] base;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef struct packed {
        logic idle;
        logic emitting;
    } back_stat_t;

    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DIGIT_TEN)
        begin
            c = CHAR_ZERO + CHAR_W'(d);
        end
        else
        begin
            c = CHAR_A + CHAR_W'(d - DIGIT_TEN);
        end
        return c;
    endfunction

endpackage

[rtl/irc_front.sv]
// ----------------------------------------------------------------------------
// irc_front
// radix register, base saturation and item accept into the job queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module irc_front
    import irc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               start,
    input  logic [VALUE_W-1:0] value,
    output logic               busy,
    input  fifo_stat_t         fifo_stat,
    output logic               push,
    output job_t               job
);

    logic [RADIX_W-1:0]   radix_reg;
    logic [RADIX_W-1:0]   radix_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;
    logic [RADIX_W-1:0]   base;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && (reg_idx == REG_RADIX);
    assign pready  = 1'b1;

    always_comb
    begin
        radix_next = radix_reg;
        if (wr_en)
        begin
            radix_next = pwdata[RADIX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
        end
        else
        begin
            radix_reg <= radix_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_RADIX)
        begin
            prdata = PDATA_W'(radix_reg);
        end
    end

    // saturate base into 2..16
    always_comb
    begin
        priority if (radix_reg < BASE_MIN)
        begin
            base = BASE_MIN;
        end
        else if (radix_reg > BASE_MAX)
        begin
            base = BASE_MAX;
        end
        else
        begin
            base = radix_reg;
        end
    end

    assign busy      = fifo_stat.full;
    assign push      = start && !fifo_stat.full;
    assign job.value = value;
    assign job.base  = base;

endmodule

[rtl/irc_fifo.sv]
// ----------------------------------------------------------------------------
// irc_fifo
// short job queue between the accept side and the conversion engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module irc_fifo
    import irc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  job_t       job_in,
    input  logic       pop,
    output job_t       job_out,
    output fifo_stat_t stat
);

    job_t                    slot_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   wr_ptr_next;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [FIFO_PTR_W-1:0]   rd_ptr_next;
    logic [FIFO_COUNT_W-1:0] count_reg;
    logic [FIFO_COUNT_W-1:0] count_next;

    function automatic logic [FIFO_PTR_W-1:0] ptr_inc(input logic [FIFO_PTR_W-1:0] p);
        logic [FIFO_PTR_W-1:0] r;
        if (p == FIFO_PTR_W'(FIFO_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + FIFO_PTR_W'(1);
        end
        return r;
    endfunction

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = ptr_inc(wr_ptr_reg);
        end
        if (pop)
        begin
            rd_ptr_next = ptr_inc(rd_ptr_reg);
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + FIFO_COUNT_W'(1);
            2'b01:   count_next = count_reg - FIFO_COUNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= job_in;
        end
    end

    assign job_out    = slot_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == FIFO_COUNT_W'(FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

[rtl/irc_back.sv]
// ----------------------------------------------------------------------------
// irc_back
// iterative divider filling the digit store, then reverse digit readout
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module irc_back
    import irc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  fifo_stat_t        fifo_stat,
    input  job_t              job,
    output logic              pop,
    output back_stat_t        stat,
    output logic              digit_strobe,
    output logic [CHAR_W-1:0] digit_char,
    output logic              last_digit
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_EMIT = 3'b100
    } back_state_t;

    back_state_t state_reg;
    back_state_t state_next;

    logic [DIGIT_W-1:0]    digit_store [DIGIT_SLOTS];

    logic [DIV_W-1:0]      sh_reg;
    logic [DIV_W-1:0]      sh_next;
    logic [REM_W-1:0]      rem_reg;
    logic [REM_W-1:0]      rem_next;
    logic [RADIX_W-1:0]    base_reg;
    logic [RADIX_W-1:0]    base_next;
    logic [STEP_W-1:0]     step_reg;
    logic [STEP_W-1:0]     step_next;
    logic [COUNT_W-1:0]    digit_count_reg;
    logic [COUNT_W-1:0]    digit_count_next;
    logic [SLOT_IDX_W-1:0] rd_idx_reg;
    logic [SLOT_IDX_W-1:0] rd_idx_next;
    logic                  rd_vld_reg;
    logic                  rd_vld_next;
    logic                  rd_last_reg;
    logic                  rd_last_next;
    logic [DIGIT_W-1:0]    rd_data_reg;

    logic [DIV_W-1:0]      sh_div;
    logic [REM_W-1:0]      rem_div;
    logic                  last_step;
    logic                  quot_zero;
    logic                  store_full;
    logic                  mem_we;
    logic                  mem_re;

    // restoring division, DIV_BITS quotient bits per cycle
    always_comb
    begin
        logic [REM_W-1:0] trial;
        logic             ge;
        rem_div = rem_reg;
        sh_div  = sh_reg;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            trial   = {rem_div[DIGIT_W-1:0], sh_div[DIV_W-1]};
            ge      = (trial >= base_reg);
            rem_div = ge ? (trial - base_reg) : trial;
            sh_div  = {sh_div[DIV_W-2:0], ge};
        end
    end

    assign last_step  = (step_reg == STEP_W'(DIV_CYCLES - 1));
    assign quot_zero  = (sh_div == '0);
    assign store_full = (digit_count_reg == COUNT_W'(DIGIT_SLOTS - 1));

    always_comb
    begin
        state_next       = state_reg;
        sh_next          = sh_reg;
        rem_next         = rem_reg;
        base_next        = base_reg;
        step_next        = step_reg;
        digit_count_next = digit_count_reg;
        rd_idx_next      = rd_idx_reg;
        rd_vld_next      = 1'b0;
        rd_last_next     = 1'b0;
        pop              = 1'b0;
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!fifo_stat.empty)
                begin
                    pop              = 1'b1;
                    sh_next          = DIV_W'(job.value);
                    base_next        = job.base;
                    rem_next         = '0;
                    step_next        = '0;
                    digit_count_next = '0;
                    state_next       = ST_DIV;
                end
            end
            ST_DIV:
            begin
                sh_next   = sh_div;
                rem_next  = rem_div;
                step_next = step_reg + STEP_W'(1);
                if (last_step)
                begin
                    mem_we           = 1'b1;
                    digit_count_next = digit_count_reg + COUNT_W'(1);
                    rem_next         = '0;
                    step_next        = '0;
                    if (quot_zero || store_full)
                    begin
                        rd_idx_next = digit_count_reg[SLOT_IDX_W-1:0];
                        state_next  = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                mem_re       = 1'b1;
                rd_vld_next  = 1'b1;
                rd_last_next = (rd_idx_reg == '0);
                rd_idx_next  = rd_idx_reg - SLOT_IDX_W'(1);
                if (rd_idx_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            step_reg        <= '0;
            digit_count_reg <= '0;
            rd_idx_reg      <= '0;
            rd_vld_reg      <= 1'b0;
            rd_last_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            step_reg        <= step_next;
            digit_count_reg <= digit_count_next;
            rd_idx_reg      <= rd_idx_next;
            rd_vld_reg      <= rd_vld_next;
            rd_last_reg     <= rd_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg   <= sh_next;
        rem_reg  <= rem_next;
        base_reg <= base_next;
    end

    // digit store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            digit_store[digit_count_reg[SLOT_IDX_W-1:0]] <= rem_div[DIGIT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rd_data_reg <= digit_store[rd_idx_reg];
        end
    end

    assign digit_strobe  = rd_vld_reg;
    assign digit_char    = digit_to_char(rd_data_reg);
    assign last_digit    = rd_last_reg;
    assign stat.idle     = (state_reg == ST_IDLE);
    assign stat.emitting = (state_reg == ST_EMIT);

endmodule

[rtl/integer_radix_converter_top.sv]
// ----------------------------------------------------------------------------
// integer_radix_converter_top
// an item's digits are resolved one by one in the divider (8 quotient bits
// per cycle) and written to the digit store; the digits then follow one per
// cycle, most significant first, and the engine takes the next item only
// once idle; a two-entry job queue accepts up to two items ahead of it
// asynchronous active-low reset: radix 10, queue empty, engine idle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "integer_radix_converter_top_macros.svh"

module integer_radix_converter_top
    import irc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               start,
    input  logic [VALUE_W-1:0] value,
    output logic               busy,
    output logic               digit_strobe,
    output logic [CHAR_W-1:0]  digit_char,
    output logic               last_digit
);

    fifo_stat_t fifo_stat;
    back_stat_t back_stat;
    logic       push;
    logic       pop;
    job_t       job_in;
    job_t       job_out;
    logic       char_ok;

    irc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .start     (start),
        .value     (value),
        .busy      (busy),
        .fifo_stat (fifo_stat),
        .push      (push),
        .job       (job_in)
    );

    irc_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .job_in  (job_in),
        .pop     (pop),
        .job_out (job_out),
        .stat    (fifo_stat)
    );

    irc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .fifo_stat    (fifo_stat),
        .job          (job_out),
        .pop          (pop),
        .stat         (back_stat),
        .digit_strobe (digit_strobe),
        .digit_char   (digit_char),
        .last_digit   (last_digit)
    );

    // digits 0-9 or A-F
    assign char_ok = ((digit_char >= CHAR_ZERO) && (digit_char <= CHAR_ZERO + CHAR_W'(9)))
                  || ((digit_char >= CHAR_A) && (digit_char <= CHAR_A + CHAR_W'(5)));

    `IRC_ASSERT_NOW(a_char_range, digit_strobe, char_ok, "digit character out of range")
    `IRC_ASSERT_NEXT(a_last_gap, digit_strobe && last_digit, !digit_strobe, "digit right after last digit")
    `IRC_ASSERT_NEXT(a_job_taken, !fifo_stat.empty && back_stat.idle, !back_stat.idle, "queued job not taken")
    `IRC_ASSERT_NEXT(a_emit_strobe, back_stat.emitting, digit_strobe, "readout without digit strobe")

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// testbench for the integer radix converter: each accepted value is expanded
// into its expected digit string at the current radix and every digit strobe
// is checked against it in order; the radix is set over the apb port between
// phases, with directed values first and then random values under varying
// sender idling
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import irc_pkg::*;

    localparam int DRAIN_CYCLES = 8;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 43;
    localparam logic [REG_IDX_W-1:0] REG_SPARE = REG_IDX_W'(1);

    class digit_string_checker;
        typedef struct {
            logic [CHAR_W-1:0] ch;
            logic              last;
        } digit_t;

        logic [RADIX_W-1:0] radix;
        digit_t             pending[$];
        int                 failures;

        function new();
            radix    = RADIX_RESET;
            failures = 0;
        endfunction

        function void note_value(logic [VALUE_W-1:0] v);
            logic [DIGIT_W-1:0] digits[$];
            int unsigned        base;
            int unsigned        rest;
            digit_t             d;
            if (radix < BASE_MIN)
            begin
                base = BASE_MIN;
            end
            else if (radix > BASE_MAX)
            begin
                base = BASE_MAX;
            end
            else
            begin
                base = radix;
            end
            rest = v;
            do
            begin
                digits.push_back(DIGIT_W'(rest % base));
                rest = rest / base;
            end
            while (rest != 0);
            for (int i = digits.size() - 1; i >= 0; i--)
            begin
                if (digits[i] < DIGIT_TEN)
                begin
                    d.ch = CHAR_ZERO + CHAR_W'(digits[i]);
                end
                else
                begin
                    d.ch = CHAR_A + CHAR_W'(digits[i] - DIGIT_TEN);
                end
                d.last = (i == 0);
                pending.push_back(d);
            end
        endfunction

        function void check_digit(logic [CHAR_W-1:0] ch, logic last);
            digit_t want;
            if (pending.size() == 0)
            begin
                $error("digit_char: no digit expected, actual %0d", ch);
                failures++;
                return;
            end
            want = pending.pop_front();
            if (ch !== want.ch)
            begin
                $error("digit_char: expected %0d actual %0d", want.ch, ch);
                failures++;
            end
            if (last !== want.last)
            begin
                $error("last_digit: expected %0d actual %0d", want.last, last);
                failures++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               start = 1'b0;
    logic [VALUE_W-1:0] value = '0;
    logic               busy;
    logic               digit_strobe;
    logic [CHAR_W-1:0]  digit_char;
    logic               last_digit;

    digit_string_checker conv = new();

    integer_radix_converter_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .start        (start),
        .value        (value),
        .busy         (busy),
        .digit_strobe (digit_strobe),
        .digit_char   (digit_char),
        .last_digit   (last_digit)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && digit_strobe)
        begin
            conv.check_digit(digit_char, last_digit);
        end
    end

    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    // all tasks are entered and left at a falling edge
    task automatic apb_access(input logic [REG_IDX_W-1:0] idx, input logic wr,
                              input logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic check_radix_reg();
        logic [PDATA_W-1:0] rdata;
        apb_access(REG_RADIX, 1'b0, '0, rdata);
        if (rdata !== PDATA_W'(conv.radix))
        begin
            $error("radix: expected %0d actual %0d", conv.radix, rdata);
            conv.failures++;
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (conv.pending.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_radix(input logic [RADIX_W-1:0] r);
        logic [PDATA_W-1:0] rdata;
        drain();
        apb_access(REG_RADIX, 1'b1, PDATA_W'(r), rdata);
        conv.radix = r;
        check_radix_reg();
    endtask

    task automatic send_item(input logic [VALUE_W-1:0] v);
        start <= 1'b1;
        value <= v;
        do
            @(posedge clk);
        while (busy);
        conv.note_value(v);
        @(negedge clk);
    endtask

    task automatic sender_gap(input int idle_pct);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
    endtask

    function automatic logic [VALUE_W-1:0] random_value();
        int unsigned w;
        logic [31:0] mask;
        w = $urandom_range(0, VALUE_W);
        mask = (w >= VALUE_W) ? 32'h7FFF_FFFF : (32'h1 << w) - 32'h1;
        return VALUE_W'($urandom & mask);
    endfunction

    initial
    begin
        logic [RADIX_W-1:0] phase_radix[PHASES];
        int                 phase_idle[PHASES];
        logic [PDATA_W-1:0] rdata;

        phase_radix = '{RADIX_W'(10), RADIX_W'(2), RADIX_W'(16), '0, '0, '0, '0, '0};
        phase_idle  = '{0, 69, 9, 0, 69, 9, 69, 0};

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        check_radix_reg();

        // reset radix
        send_item(VALUE_W'(0));
        send_item(VALUE_W'(1));
        send_item(VALUE_W'(9));
        send_item(VALUE_W'(10));
        send_item(VALUE_W'(32'h7FFF_FFFF));
        send_item(VALUE_W'(1234567890));

        set_radix(RADIX_W'(16));
        send_item(VALUE_W'(32'h7FFF_FFFF));
        send_item(VALUE_W'(32'h7EDC_BA98));
        send_item(VALUE_W'(32'h0123_4567));
        send_item(VALUE_W'(15));
        send_item(VALUE_W'(16));

        set_radix(RADIX_W'(2));
        send_item(VALUE_W'(32'h7FFF_FFFF));
        send_item(VALUE_W'(32'h5555_5555));
        send_item(VALUE_W'(32'h2AAA_AAAA));
        send_item(VALUE_W'(2));

        // radix below two runs as base two
        set_radix(RADIX_W'(0));
        send_item(VALUE_W'(5));
        send_item(VALUE_W'(0));
        set_radix(RADIX_W'(1));
        send_item(VALUE_W'(6));

        // radix above sixteen runs as base sixteen
        set_radix(RADIX_W'(17));
        send_item(VALUE_W'(32'h7FFF_FFFF));
        set_radix(RADIX_W'(31));
        send_item(VALUE_W'(255));

        // write to an unused address is dropped
        set_radix(RADIX_W'(3));
        drain();
        apb_access(REG_SPARE, 1'b1, $urandom, rdata);
        check_radix_reg();
        send_item(VALUE_W'(32'h7FFF_FFFF));

        for (int p = 0; p < PHASES; p++)
        begin
            if (p < 3)
            begin
                set_radix(phase_radix[p]);
            end
            else
            begin
                set_radix(RADIX_W'($urandom_range(0, 31)));
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                sender_gap(phase_idle[p]);
                if ($urandom_range(0, 39) == 0)
                begin
                    drain();
                end
                send_item(random_value());
            end
        end

        start <= 1'b0;
        while (conv.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (conv.failures == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
